// File: rtl/core/bbd_pkg.sv
// ----------------------------------------------------------------------------
// bbd_pkg: shared types and constants of the base64 byte decoder
// Holds the result kinds, the character classes and the token that the
// front end hands to the back end through the queue.
// ----------------------------------------------------------------------------
package bbd_pkg;

  // Widths fixed by the item formats.
  localparam int CHAR_W       = 8;
  localparam int SYM_W        = 6;
  localparam int BYTE_W       = 8;
  localparam int BYTE_COUNT_W = 16;
  localparam int CAP_W        = 16;

  // Defaults for the top-level parameters and the capacity register.
  localparam int             COUNT_WIDTH_DEF = 16;
  localparam logic [CAP_W-1:0] CAP_RESET     = 16'd1024;

  // Kind of a result item.
  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_END   = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  // Class of one incoming character.
  typedef enum logic [1:0] {
    CLS_SYMBOL  = 2'd0,
    CLS_TERM    = 2'd1,
    CLS_INVALID = 2'd2
  } char_class_t;

  // Classified character as it travels from the front end to the back end.
  typedef struct packed {
    logic              start;
    char_class_t       cls;
    logic [SYM_W-1:0]  value;
  } token_t;

endpackage

// File: rtl/core/bbd_ifs.sv
// ----------------------------------------------------------------------------
// bbd_ifs: valid/ready channels of the base64 byte decoder
// One channel carries characters in, the other carries result items out.
// ----------------------------------------------------------------------------
interface bbd_char_if;
  import bbd_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              payload_start;

  modport source (output valid, output char_code, output payload_start, input ready);
  modport sink   (input valid, input char_code, input payload_start, output ready);
endinterface

interface bbd_result_if;
  import bbd_pkg::*;

  logic                    valid;
  logic                    ready;
  kind_t                   kind;
  logic signed [BYTE_W-1:0] data_byte;
  logic [BYTE_COUNT_W-1:0] byte_count;

  modport source (output valid, output kind, output data_byte, output byte_count,
                  input ready);
  modport sink   (input valid, input kind, input data_byte, input byte_count,
                  output ready);
endinterface

// File: rtl/core/bbd_front.sv
// ----------------------------------------------------------------------------
// bbd_front: character intake and classification
// Accepts a character request whenever the queue has room and turns it into
// a token: its class (symbol, terminator, invalid) and its six-bit value.
// ----------------------------------------------------------------------------
module bbd_front (
  bbd_char_if.sink        char_in,
  input  logic            queue_ready,
  output logic            push,
  output bbd_pkg::token_t push_token
);
  import bbd_pkg::*;

  localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0a;
  localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0d;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_EQUAL = 8'h3d;
  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2b;
  localparam logic [CHAR_W-1:0] CHAR_SLASH = 8'h2f;
  localparam logic [CHAR_W-1:0] CHAR_UP_A  = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_UP_Z  = 8'h5a;
  localparam logic [CHAR_W-1:0] CHAR_LO_A  = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_LO_Z  = 8'h7a;
  localparam logic [CHAR_W-1:0] CHAR_D0    = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_D9    = 8'h39;

  localparam logic [CHAR_W-1:0] LOWER_BASE = 8'd26;
  localparam logic [CHAR_W-1:0] DIGIT_BASE = 8'd52;
  localparam logic [SYM_W-1:0]  PLUS_VAL   = 6'd62;
  localparam logic [SYM_W-1:0]  SLASH_VAL  = 6'd63;

  logic [CHAR_W-1:0] code;
  logic [CHAR_W-1:0] sym_full;
  char_class_t       cls;

  assign code = char_in.char_code;

  // Map the character to its class and base64 value.
  always_comb begin
    sym_full = '0;
    cls      = CLS_INVALID;
    if (code == CHAR_NUL || code == CHAR_TAB || code == CHAR_LF ||
        code == CHAR_CR || code == CHAR_SPACE || code == CHAR_EQUAL) begin
      cls = CLS_TERM;
    end else if (code >= CHAR_UP_A && code <= CHAR_UP_Z) begin
      cls      = CLS_SYMBOL;
      sym_full = code - CHAR_UP_A;
    end else if (code >= CHAR_LO_A && code <= CHAR_LO_Z) begin
      cls      = CLS_SYMBOL;
      sym_full = code - CHAR_LO_A + LOWER_BASE;
    end else if (code >= CHAR_D0 && code <= CHAR_D9) begin
      cls      = CLS_SYMBOL;
      sym_full = code - CHAR_D0 + DIGIT_BASE;
    end else if (code == CHAR_PLUS) begin
      cls      = CLS_SYMBOL;
      sym_full = {2'b00, PLUS_VAL};
    end else if (code == CHAR_SLASH) begin
      cls      = CLS_SYMBOL;
      sym_full = {2'b00, SLASH_VAL};
    end
  end

  // A request is taken whenever the queue can hold it.
  assign char_in.ready    = queue_ready;
  assign push             = char_in.valid && queue_ready;
  assign push_token.start = char_in.payload_start;
  assign push_token.cls   = cls;
  assign push_token.value = sym_full[SYM_W-1:0];

endmodule

// File: rtl/core/bbd_queue.sv
// ----------------------------------------------------------------------------
// bbd_queue: short token queue between front end and back end
// A two-entry FIFO that lets either side stall without stopping the other.
// ----------------------------------------------------------------------------
module bbd_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  bbd_pkg::token_t push_token,
  output logic            push_ready,
  input  logic            pop,
  output logic            head_valid,
  output bbd_pkg::token_t head_token
);
  import bbd_pkg::*;

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  token_t             entries [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   fill;

  assign push_ready = (fill != CNT_W'(DEPTH));
  assign head_valid = (fill != '0);
  assign head_token = entries[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_token;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// File: rtl/core/bbd_back.sv
// ----------------------------------------------------------------------------
// bbd_back: bit accumulation and result generation
// Takes one queue token per cycle unless the output register stalls, shifts
// symbol bits into the accumulator, emits bytes, end and error results to it.
// ----------------------------------------------------------------------------
module bbd_back #(
  parameter int COUNT_WIDTH = bbd_pkg::COUNT_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [bbd_pkg::CAP_W-1:0]  cfg_wr_data,
  input  logic                       head_valid,
  input  bbd_pkg::token_t            head_token,
  output logic                       pop,
  bbd_result_if.source               result_out
);
  import bbd_pkg::*;

  localparam int ACC_W  = 12;
  localparam int PEND_W = 4;
  localparam int CMP_W  = (COUNT_WIDTH > CAP_W) ? COUNT_WIDTH : CAP_W;
  localparam logic [PEND_W-1:0] PEND_STEP = 4'd6;
  localparam logic [PEND_W-1:0] PEND_MAX  = 4'd12;
  localparam logic [PEND_W-1:0] PEND_BYTE = 4'd8;
  localparam logic [COUNT_WIDTH-1:0] COUNT_LIMIT = '1;

  // Decoder state.
  logic [CAP_W-1:0]       capacity;
  logic [ACC_W-1:0]       acc;
  logic [PEND_W-1:0]      pend;
  logic [COUNT_WIDTH-1:0] produced_count;
  logic                   stopped;

  // State as seen by the head token, after a payload start.
  logic [ACC_W-1:0]       acc_eff;
  logic [PEND_W-1:0]      pend_eff;
  logic [COUNT_WIDTH-1:0] cnt_eff;
  logic                   stop_eff;

  logic [ACC_W-1:0]       acc_next;
  logic [PEND_W-1:0]      pend_next;
  logic [COUNT_WIDTH-1:0] count_next;
  logic                   stopped_next;

  logic [PEND_W-1:0]      pend_sum;
  logic [PEND_W-1:0]      pend_clamp;
  logic [PEND_W-1:0]      shift;
  logic [ACC_W-1:0]       acc_shifted;
  logic                   cap_hit;

  logic                   res_valid;
  kind_t                  res_kind;
  logic [BYTE_W-1:0]      res_byte;

  // Bit and count arithmetic for the head token.
  always_comb begin
    acc_eff  = head_token.start ? '0 : acc;
    pend_eff = head_token.start ? '0 : pend;
    cnt_eff  = head_token.start ? '0 : produced_count;
    stop_eff = head_token.start ? 1'b0 : stopped;

    pend_sum    = pend_eff + PEND_STEP;
    pend_clamp  = (pend_sum > PEND_MAX) ? PEND_MAX : pend_sum;
    shift       = pend_clamp - PEND_BYTE;
    acc_shifted = {acc_eff[ACC_W-SYM_W-1:0], head_token.value} >> shift;
    cap_hit     = (CMP_W'(cnt_eff) >= CMP_W'(capacity)) || (cnt_eff == COUNT_LIMIT);
  end

  // Result and next state for the head token.
  always_comb begin
    acc_next     = acc_eff;
    pend_next    = pend_eff;
    count_next   = cnt_eff;
    stopped_next = stop_eff;
    res_valid    = 1'b0;
    res_kind     = KIND_BYTE;
    res_byte     = '0;
    if (!stop_eff) begin
      case (head_token.cls)
        CLS_TERM: begin
          stopped_next = 1'b1;
          res_valid    = 1'b1;
          res_kind     = KIND_END;
        end
        CLS_SYMBOL: begin
          acc_next  = {acc_eff[ACC_W-SYM_W-1:0], head_token.value};
          pend_next = pend_clamp;
          if (pend_clamp >= PEND_BYTE) begin
            res_valid = 1'b1;
            if (cap_hit) begin
              stopped_next = 1'b1;
              res_kind     = KIND_ERROR;
            end else begin
              res_byte   = acc_shifted[BYTE_W-1:0];
              pend_next  = shift;
              count_next = cnt_eff + 1'b1;
            end
          end
        end
        default: begin
          stopped_next = 1'b1;
          res_valid    = 1'b1;
          res_kind     = KIND_ERROR;
        end
      endcase
    end
  end

  // The head token is taken when the output register is free or draining.
  assign pop = head_valid && (!result_out.valid || result_out.ready);

  // Capacity register and decoder state.
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity       <= CAP_RESET;
      acc            <= '0;
      pend           <= '0;
      produced_count <= '0;
      stopped        <= 1'b1;
    end else begin
      if (cfg_wr_en) begin
        capacity <= cfg_wr_data;
      end
      if (pop) begin
        acc            <= acc_next;
        pend           <= pend_next;
        produced_count <= count_next;
        stopped        <= stopped_next;
      end
    end
  end

  // Output register valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_out.valid <= 1'b0;
    end else if (pop) begin
      result_out.valid <= res_valid;
    end else if (result_out.ready) begin
      result_out.valid <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (pop && res_valid) begin
      result_out.kind       <= res_kind;
      result_out.data_byte  <= res_byte;
      result_out.byte_count <= BYTE_COUNT_W'(count_next);
    end
  end

`ifndef SYNTHESIS
  // End and error results leave the decoder stopped.
  assert property (@(posedge clk) disable iff (rst)
    (pop && res_valid && res_kind != KIND_BYTE) |=> stopped)
    else $error("decoder not stopped after end or error result");

  // Each emitted byte advances the count by exactly one.
  assert property (@(posedge clk) disable iff (rst)
    (pop && res_valid && res_kind == KIND_BYTE) |=>
      (produced_count == $past(cnt_eff) + 1'b1))
    else $error("byte count did not advance by one");

  // While a payload is open the held bits stay below one full byte.
  assert property (@(posedge clk) disable iff (rst)
    !stopped |-> (pend < PEND_BYTE))
    else $error("held bit count reached a full byte");

  // A waiting result blocks the queue.
  assert property (@(posedge clk) disable iff (rst)
    (result_out.valid && !result_out.ready) |-> !pop)
    else $error("token taken while result register is held");
`endif

endmodule

// File: rtl/core/base64_byte_decoder.sv
// ----------------------------------------------------------------------------
// base64_byte_decoder: streaming base64 payload decoder
// Decodes base64 characters into bytes and reports payload end or error.
// ----------------------------------------------------------------------------
// The decoder takes one character request per clock while the token queue has
// room and returns at most one result per character: a decoded byte, a payload
// end with its byte count, or an error. A character marked as payload start
// re-arms the decoder; characters after an end or an error are dropped until
// then. Sustained throughput is one character per cycle while the receiver
// takes results. An accepted character passes the two-entry token queue and
// then the output register, which lets the input side keep accepting while a
// result waits to be taken. The capacity register, the most bytes one payload
// may produce, is written through cfg_wr_en and cfg_wr_data and takes effect
// for the characters decoded after the write.
// ----------------------------------------------------------------------------
module base64_byte_decoder #(
  parameter int COUNT_WIDTH = bbd_pkg::COUNT_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [bbd_pkg::CAP_W-1:0] cfg_wr_data,
  bbd_char_if.sink                  char_in,
  bbd_result_if.source              result_out
);
  import bbd_pkg::*;

  logic   push;
  logic   queue_ready;
  token_t push_token;
  logic   pop;
  logic   head_valid;
  token_t head_token;

  // Intake and classification.
  bbd_front u_front (
    .char_in     (char_in),
    .queue_ready (queue_ready),
    .push        (push),
    .push_token  (push_token)
  );

  // Token queue.
  bbd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_token (push_token),
    .push_ready (queue_ready),
    .pop        (pop),
    .head_valid (head_valid),
    .head_token (head_token)
  );

  // Decoding and results.
  bbd_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .head_valid  (head_valid),
    .head_token  (head_token),
    .pop         (pop),
    .result_out  (result_out)
  );

endmodule

// File: tb/sv/base64_byte_decoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_byte_decoder_tb: self-checking testbench of the base64 byte decoder
// Streams directed and random base64 payloads, broken payloads and noise into
// the character channel. A local decoder model predicts every result, and the
// result channel is checked field by field. Both sides idle and stall at
// random, and the receiver holds off for long stretches now and then.
// ----------------------------------------------------------------------------
module base64_byte_decoder_tb;
  import bbd_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned MAX_PRINTED  = 30;
  localparam int unsigned RANDOM_CHARS = 1400;
  localparam logic [COUNT_WIDTH_DEF-1:0] COUNT_MAX = '1;

  // Characters that end a payload.
  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PAD   = 8'h3D;

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              start;
  } char_req_t;

  typedef struct packed {
    kind_t                    kind;
    logic signed [BYTE_W-1:0] data_byte;
    logic [BYTE_COUNT_W-1:0]  byte_count;
  } decode_result_t;

  typedef enum int {TAIL_TERM, TAIL_INVALID, TAIL_NONE} payload_tail_t;
  typedef enum int {RDY_ALWAYS, RDY_RANDOM, RDY_PATTERN} ready_style_t;

  logic                 clk         = 1'b0;
  logic                 rst         = 1'b1;
  logic                 cfg_wr_en   = 1'b0;
  logic [CAP_W-1:0]     cfg_wr_data = CAP_RESET;
  logic                 drv_valid   = 1'b0;
  logic [CHAR_W-1:0]    drv_code    = '0;
  logic                 drv_start   = 1'b0;
  logic                 rsp_ready   = 1'b0;

  bbd_char_if   char_ch ();
  bbd_result_if result_ch ();

  assign char_ch.valid         = drv_valid;
  assign char_ch.char_code     = drv_code;
  assign char_ch.payload_start = drv_start;
  assign result_ch.ready       = rsp_ready;

  base64_byte_decoder u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .char_in     (char_ch),
    .result_out  (result_ch)
  );

  // Free-running clock, 20 ns period.
  always #10 clk = ~clk;

  int unsigned cycle_count = 0;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Characters waiting to be offered and results still owed by the block.
  char_req_t      char_backlog[$];
  decode_result_t expected_results[$];

  int unsigned pushed_chars   = 0;
  int unsigned accepted_chars = 0;
  int unsigned fail_count     = 0;
  int unsigned n_bytes        = 0;
  int unsigned n_ends         = 0;
  int unsigned n_errors       = 0;
  int unsigned cap_writes     = 0;

  // Local copy of the decoder state and of the capacity register.
  logic [11:0]                acc_bits   = '0;
  logic [3:0]                 held_bits  = '0;
  logic [COUNT_WIDTH_DEF-1:0] bytes_made = '0;
  logic                       halted     = 1'b1;
  logic [CAP_W-1:0]           cap_value  = CAP_RESET;

  // Six-bit value of a base64 symbol, or -1 for any other code.
  function automatic int symbol_of(input logic [CHAR_W-1:0] c);
    if (c >= "A" && c <= "Z") return int'(c) - int'("A");
    if (c >= "a" && c <= "z") return int'(c) - int'("a") + 26;
    if (c >= "0" && c <= "9") return int'(c) - int'("0") + 52;
    if (c == "+") return 62;
    if (c == "/") return 63;
    return -1;
  endfunction

  function automatic bit ends_payload(input logic [CHAR_W-1:0] c);
    return c == CH_NUL || c == CH_CR || c == CH_LF || c == CH_SPACE ||
           c == CH_TAB || c == CH_PAD;
  endfunction

  function automatic logic [CHAR_W-1:0] symbol_char(input int v);
    if (v < 26) return 8'(int'("A") + v);
    if (v < 52) return 8'(int'("a") + v - 26);
    if (v < 62) return 8'(int'("0") + v - 52);
    if (v == 62) return "+";
    return "/";
  endfunction

  function automatic logic [CHAR_W-1:0] any_symbol();
    return symbol_char(int'($urandom_range(0, 63)));
  endfunction

  function automatic logic [CHAR_W-1:0] any_terminator();
    case ($urandom_range(0, 5))
      0: return CH_NUL;
      1: return CH_TAB;
      2: return CH_LF;
      3: return CH_CR;
      4: return CH_SPACE;
      default: return CH_PAD;
    endcase
  endfunction

  function automatic logic [CHAR_W-1:0] any_invalid();
    logic [CHAR_W-1:0] c;
    do c = 8'($urandom_range(0, 255));
    while (symbol_of(c) >= 0 || ends_payload(c));
    return c;
  endfunction

  // Decode one accepted character and queue the result it causes, if any.
  task automatic predict_char(input logic [CHAR_W-1:0] c, input logic s);
    int             v;
    logic [3:0]     nb;
    decode_result_t r;
    if (s) begin
      acc_bits   = '0;
      held_bits  = '0;
      bytes_made = '0;
      halted     = 1'b0;
    end
    if (halted) return;
    r.data_byte  = '0;
    r.byte_count = bytes_made[BYTE_COUNT_W-1:0];
    if (ends_payload(c)) begin
      halted = 1'b1;
      r.kind = KIND_END;
      expected_results.push_back(r);
      return;
    end
    v = symbol_of(c);
    if (v < 0) begin
      halted = 1'b1;
      r.kind = KIND_ERROR;
      expected_results.push_back(r);
      return;
    end
    acc_bits = {acc_bits[5:0], v[5:0]};
    nb = held_bits + 4'd6;
    if (nb > 4'd12) nb = 4'd12;
    held_bits = nb;
    if (nb < 4'd8) return;
    // A byte past the capacity, or with the counter full, is an error.
    if (bytes_made >= cap_value || bytes_made == COUNT_MAX) begin
      halted = 1'b1;
      r.kind = KIND_ERROR;
      expected_results.push_back(r);
      return;
    end
    r.kind       = KIND_BYTE;
    r.data_byte  = 8'(acc_bits >> (nb - 4'd8));
    held_bits    = nb - 4'd8;
    bytes_made   = bytes_made + 1'b1;
    r.byte_count = bytes_made[BYTE_COUNT_W-1:0];
    expected_results.push_back(r);
  endtask

  task automatic report_mismatch(input string what);
    fail_count++;
    if (fail_count <= MAX_PRINTED)
      $display("mismatch at cycle %0d: %s", cycle_count, what);
  endtask

  task automatic push_char(input logic [CHAR_W-1:0] c, input logic s);
    char_backlog.push_back('{code: c, start: s});
    pushed_chars++;
  endtask

  task automatic push_text(input string txt, input logic start_first);
    for (int i = 0; i < txt.len(); i++)
      push_char(txt[i], start_first && i == 0);
  endtask

  // One payload of random symbols with the chosen ending.
  task automatic push_payload(input int nsym, input payload_tail_t tail);
    push_char(any_symbol(), 1'b1);
    for (int i = 1; i < nsym; i++)
      push_char(any_symbol(), 1'b0);
    case (tail)
      TAIL_TERM:    push_char(any_terminator(), 1'b0);
      TAIL_INVALID: push_char(any_invalid(), 1'b0);
      default:      ;
    endcase
    // Now and then a stray character that the stopped decoder drops.
    if (tail != TAIL_NONE && $urandom_range(0, 3) == 0)
      push_char(8'($urandom_range(0, 255)), 1'b0);
  endtask

  // Mostly well-formed payloads, the rest broken payloads and noise.
  task automatic random_phase(input int unsigned n_chars);
    int unsigned goal;
    int unsigned pick;
    int          len;
    goal = pushed_chars + n_chars;
    while (pushed_chars < goal) begin
      pick = $urandom_range(0, 99);
      len  = ($urandom_range(0, 9) == 0) ? int'($urandom_range(25, 60))
                                         : int'($urandom_range(1, 12));
      if (pick < 70)
        push_payload(len, TAIL_TERM);
      else if (pick < 80)
        push_payload(len, TAIL_INVALID);
      else if (pick < 90)
        push_payload(len, TAIL_NONE);
      else
        repeat ($urandom_range(1, 4))
          push_char(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
    end
  endtask

  // Wait until every character is taken and every result is in, then let
  // the pipeline settle on characters that cause no result.
  task automatic drain();
    while (accepted_chars != pushed_chars || expected_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] value);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    cap_value   = value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cap_writes++;
  endtask

  // Request driver: bursts of random length separated by random gaps.
  int unsigned burst_left = 1;
  int unsigned gap_left   = 0;

  always @(posedge clk) begin : char_driver
    char_req_t next_req;
    if (rst) begin
      drv_valid <= 1'b0;
    end else begin
      if (drv_valid && char_ch.ready) begin
        predict_char(drv_code, drv_start);
        accepted_chars++;
      end
      if (!drv_valid || char_ch.ready) begin
        if (gap_left != 0) begin
          gap_left--;
          drv_valid <= 1'b0;
        end else if (char_backlog.size() != 0) begin
          next_req = char_backlog.pop_front();
          drv_valid <= 1'b1;
          drv_code  <= next_req.code;
          drv_start <= next_req.start;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 32);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          drv_valid <= 1'b0;
        end
      end
    end
  end

  // Periodic long receiver hold-off, so the block fills up.
  int unsigned hold_left = 0;

  always @(posedge clk) begin : hold_off_ctl
    if (rst) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (cycle_count % 2000 == 500) begin
      hold_left <= 400;
    end
  end

  // Receiver ready: stretches of full rate, random stalls or a rotating
  // stall pattern.
  int unsigned  mode_left     = 0;
  ready_style_t ready_mode    = RDY_ALWAYS;
  logic [15:0]  stall_pattern = 16'hFFFF;

  always @(posedge clk) begin : result_ready_gen
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        ready_mode    = ready_style_t'($urandom_range(0, 2));
        mode_left     = $urandom_range(20, 200);
        stall_pattern = 16'($urandom) | 16'h0001;
      end else begin
        mode_left--;
      end
      if (hold_left != 0) begin
        rsp_ready <= 1'b0;
      end else begin
        case (ready_mode)
          RDY_ALWAYS: rsp_ready <= 1'b1;
          RDY_RANDOM: rsp_ready <= ($urandom_range(0, 3) != 0);
          default: begin
            rsp_ready     <= stall_pattern[0];
            stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
          end
        endcase
      end
    end
  end

  // Result monitor: compare each accepted result with the oldest prediction.
  always @(posedge clk) begin : result_monitor
    decode_result_t want;
    if (!rst && result_ch.valid && rsp_ready) begin
      case (result_ch.kind)
        KIND_BYTE: n_bytes++;
        KIND_END:  n_ends++;
        default:   n_errors++;
      endcase
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result kind %0d count %0d with none predicted",
                                  result_ch.kind, result_ch.byte_count));
      end else begin
        want = expected_results.pop_front();
        if (result_ch.kind !== want.kind)
          report_mismatch($sformatf("kind %0d, predicted %0d",
                                    result_ch.kind, want.kind));
        if (result_ch.data_byte !== want.data_byte)
          report_mismatch($sformatf("data_byte %0d, predicted %0d",
                                    result_ch.data_byte, want.data_byte));
        if (result_ch.byte_count !== want.byte_count)
          report_mismatch($sformatf("byte_count %0d, predicted %0d",
                                    result_ch.byte_count, want.byte_count));
      end
    end
  end

  // Stimulus and phase control.
  initial begin : stimulus
    logic [CAP_W-1:0] phase_caps [5];
    phase_caps[0] = 16'($urandom_range(2, 6));
    phase_caps[1] = 16'hFFFF;
    phase_caps[2] = 16'($urandom_range(7, 40));
    phase_caps[3] = 16'd1;
    phase_caps[4] = 16'($urandom_range(1, 65535));

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed part at the reset capacity.
    push_char("A", 1'b0);             // dropped: still waiting after reset
    push_char(CH_PAD, 1'b1);          // terminator as first character
    push_text("//AA+9az0Z", 1'b1);    // symbol class boundaries, all-ones bytes
    push_char(CH_TAB, 1'b0);
    push_char(8'hFF, 1'b1);           // invalid first character
    push_char("B", 1'b0);             // dropped after the error
    push_char(CH_NUL, 1'b1);
    push_char(CH_CR, 1'b1);
    push_char(CH_LF, 1'b1);
    push_char(CH_SPACE, 1'b1);
    push_text("gx", 1'b1);            // one byte, then an invalid code
    push_char(8'h80, 1'b0);
    push_text("Qk", 1'b1);            // restart in the middle of a payload
    push_text("TWFu", 1'b1);
    push_char(CH_PAD, 1'b0);
    drain();

    // Capacity zero: the first byte of every payload is an error.
    write_capacity(16'd0);
    push_text("AA", 1'b1);
    push_char(CH_PAD, 1'b1);
    push_text("/A", 1'b1);
    drain();

    // Capacity one.
    write_capacity(16'd1);
    push_text("AAAA", 1'b1);
    push_text("AA=", 1'b1);
    drain();

    // Random phases over several capacities.
    foreach (phase_caps[i]) begin
      write_capacity(phase_caps[i]);
      random_phase(RANDOM_CHARS / 5);
      drain();
    end

    $display("Covered %0d characters: %0d bytes, %0d payload ends, %0d errors reported.",
             accepted_chars, n_bytes, n_ends, n_errors);
    $display("Capacity written %0d times, from zero and one up to full scale.",
             cap_writes);
    if (fail_count == 0) begin
      $display("[base64_byte_decoder] OK");
    end else begin
      $display("[base64_byte_decoder] ERROR");
    end
    $finish;
  end

  // Watchdog on the whole run.
  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Run stopped at cycle %0d with %0d results outstanding.",
             cycle_count, expected_results.size());
    $display("[base64_byte_decoder] ERROR");
    $finish;
  end

endmodule

// File: base64_byte_decoder.f
rtl/core/bbd_pkg.sv
rtl/core/bbd_ifs.sv
rtl/core/bbd_front.sv
rtl/core/bbd_queue.sv
rtl/core/bbd_back.sv
rtl/core/base64_byte_decoder.sv
tb/sv/base64_byte_decoder_tb.sv
